// File: hw/rtl/brf_pkg.sv
// Package for the byte ring FIFO with staged commit.
// Holds payload structs, opcodes, status codes, the FSM state type and defaults.
// No dependencies.
package brf_pkg;

    localparam int DEPTH_DEF     = 1024;
    localparam int MAX_BURST_DEF = 64;
    localparam int SIZE_W        = 11;
    localparam int CNT_W         = 7;
    localparam int SIZE_RESET    = 1024;

    // opcodes
    localparam logic [2:0] OP_WRITE  = 3'd0;
    localparam logic [2:0] OP_COMMIT = 3'd1;
    localparam logic [2:0] OP_READ   = 3'd2;
    localparam logic [2:0] OP_PEEK   = 3'd3;
    localparam logic [2:0] OP_STATUS = 3'd4;

    // result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_OVERFLOW = 2'd1;
    localparam logic [1:0] ST_EMPTY    = 2'd2;

    typedef struct packed {
        logic [2:0]       opcode;
        logic [7:0]       data_in;
        logic             block_first;
        logic [CNT_W-1:0] count;
    } t_in;

    typedef struct packed {
        logic [7:0]        data_out;
        logic              byte_valid;
        logic              last;
        logic [1:0]        status;
        logic [SIZE_W-1:0] fill_level;
        logic [SIZE_W-1:0] free_space;
    } t_out;

    typedef enum logic {
        S_IDLE,
        S_BURST
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic acc;        // input item accepted
        logic meta_load;  // load a single non-byte result into the stage
        logic rd_en;      // issue one burst byte read
        logic out_load;   // move stage into output register
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic is_burst;   // current input is a read/peek with bytes to give
        logic last_issue; // next burst read is the final one
    } t_sts;

endpackage

// File: hw/rtl/brf_ctrl.sv
// Controller for the byte ring FIFO: FSM, stage and output valid flags.
// Depends on brf_pkg.
module brf_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    input  brf_pkg::t_sts i_sts,
    output brf_pkg::t_cmd o_cmd
);
    import brf_pkg::*;

    t_state r_state, n_state;
    logic   r_s1_v, n_s1_v;
    logic   r_o_valid, n_o_valid;
    t_cmd   cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_s1_v    <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_s1_v    <= n_s1_v;
            r_o_valid <= n_o_valid;
        end
    end

    always_comb begin
        n_state       = r_state;
        cmd.out_load  = r_s1_v && (!r_o_valid || i_out_ready);
        cmd.acc       = 1'b0;
        cmd.meta_load = 1'b0;
        cmd.rd_en     = 1'b0;
        o_in_ready    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready    = !r_s1_v || cmd.out_load;
                cmd.acc       = i_in_valid && o_in_ready;
                cmd.meta_load = cmd.acc && !i_sts.is_burst;
                if (cmd.acc && i_sts.is_burst) begin
                    n_state = S_BURST;
                end
            end
            S_BURST: begin
                cmd.rd_en = !r_s1_v || cmd.out_load;
                if (cmd.rd_en && i_sts.last_issue) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (cmd.meta_load || cmd.rd_en) begin
            n_s1_v = 1'b1;
        end else if (cmd.out_load) begin
            n_s1_v = 1'b0;
        end else begin
            n_s1_v = r_s1_v;
        end

        if (cmd.out_load) begin
            n_o_valid = 1'b1;
        end else if (i_out_ready) begin
            n_o_valid = 1'b0;
        end else begin
            n_o_valid = r_o_valid;
        end
    end

    assign o_cmd       = cmd;
    assign o_out_valid = r_o_valid;

endmodule

// File: hw/rtl/brf_dp.sv
// Datapath for the byte ring FIFO: pointers, ring memory, result stage and output.
// Depends on brf_pkg; driven by brf_ctrl commands.
module brf_dp #(
    parameter int DEPTH     = brf_pkg::DEPTH_DEF,
    parameter int MAX_BURST = brf_pkg::MAX_BURST_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  brf_pkg::t_in              i_item,
    input  logic                      i_cfg_we,
    input  logic [brf_pkg::SIZE_W-1:0] i_cfg_data,
    input  brf_pkg::t_cmd             i_cmd,
    output brf_pkg::t_sts             o_sts,
    output brf_pkg::t_out             o_result
);
    import brf_pkg::*;

    localparam int PTR_W    = $clog2(DEPTH);
    localparam int AW       = ((PTR_W > SIZE_W) ? PTR_W : SIZE_W) + 1;
    localparam int BL_W     = $clog2(MAX_BURST + 1);
    localparam int SIZE_RST = (DEPTH < SIZE_RESET) ? DEPTH : SIZE_RESET;

    logic [7:0]        mem [DEPTH];

    logic [SIZE_W-1:0] r_size;
    logic [PTR_W-1:0]  r_rd_pos, r_cm_end, r_st_end;
    logic              r_drop;
    logic [CNT_W-1:0]  r_left;
    logic [PTR_W-1:0]  r_burst_ptr;
    logic [BL_W-1:0]   r_burst_left;
    logic [7:0]        r_rd_q;
    logic              r_s1_byte, r_s1_last;
    logic [1:0]        r_s1_status;
    logic [SIZE_W-1:0] r_res_fill, r_res_free;
    t_out              r_out;

    logic [AW-1:0] size_x, rd_x, cm_x, st_x, cnt_x, cfg_x;
    logic [AW-1:0] fill_now, fill_commit, fill_after, staged_rest;
    logic [AW-1:0] n_lim, n_bytes, rd_adv, st_inc, bp_inc;
    logic [SIZE_W-1:0] n_size;
    logic          is_write, overflow, store;
    logic [1:0]    meta_status;

    assign size_x = AW'(r_size);
    assign rd_x   = AW'(r_rd_pos);
    assign cm_x   = AW'(r_cm_end);
    assign st_x   = AW'(r_st_end);
    assign cnt_x  = AW'(i_item.count);
    assign cfg_x  = AW'(i_cfg_data);

    always_comb begin
        fill_now    = (cm_x >= rd_x) ? cm_x - rd_x : size_x + cm_x - rd_x;
        fill_commit = (st_x >= rd_x) ? st_x - rd_x : size_x + st_x - rd_x;
        staged_rest = (rd_x > st_x) ? rd_x - st_x : size_x - (st_x - rd_x);

        n_lim   = (cnt_x > AW'(MAX_BURST)) ? AW'(MAX_BURST) : cnt_x;
        n_bytes = (n_lim > fill_now) ? fill_now : n_lim;
        rd_adv  = rd_x + n_bytes;
        if (rd_adv >= size_x) begin
            rd_adv = rd_adv - size_x;
        end
        st_inc = st_x + AW'(1);
        if (st_inc >= size_x) begin
            st_inc = '0;
        end
        bp_inc = AW'(r_burst_ptr) + AW'(1);
        if (bp_inc >= size_x) begin
            bp_inc = '0;
        end

        is_write = (i_item.opcode == OP_WRITE);
        overflow = i_item.block_first && (staged_rest <= cnt_x);
        store    = is_write && (i_item.block_first
                   ? (!overflow && i_item.count != '0)
                   : (!r_drop && r_left != '0));

        meta_status = ST_OK;
        fill_after  = fill_now;
        case (i_item.opcode)
            OP_WRITE:  meta_status = overflow ? ST_OVERFLOW : ST_OK;
            OP_COMMIT: fill_after  = fill_commit;
            OP_READ: begin
                fill_after  = fill_now - n_bytes;
                meta_status = ST_EMPTY;
            end
            OP_PEEK:   meta_status = ST_EMPTY;
            default:   meta_status = ST_OK;
        endcase

        // ring size write, clamped to the usable range
        if (cfg_x < AW'(2)) begin
            n_size = SIZE_W'(2);
        end else if (cfg_x > AW'(DEPTH)) begin
            n_size = SIZE_W'(DEPTH);
        end else begin
            n_size = i_cfg_data;
        end
    end

    assign o_sts.is_burst   = (i_item.opcode == OP_READ || i_item.opcode == OP_PEEK)
                              && (n_bytes != '0);
    assign o_sts.last_issue = (r_burst_left == BL_W'(1));

    // pointer and block state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size   <= SIZE_W'(SIZE_RST);
            r_rd_pos <= '0;
            r_cm_end <= '0;
            r_st_end <= '0;
            r_drop   <= 1'b0;
            r_left   <= '0;
        end else if (i_cfg_we) begin
            r_size   <= n_size;
            r_rd_pos <= '0;
            r_cm_end <= '0;
            r_st_end <= '0;
            r_drop   <= 1'b0;
            r_left   <= '0;
        end else if (i_cmd.acc) begin
            if (store) begin
                r_st_end <= PTR_W'(st_inc);
            end
            case (i_item.opcode)
                OP_WRITE: begin
                    if (i_item.block_first) begin
                        r_drop <= overflow;
                        r_left <= (overflow || i_item.count == '0)
                                  ? '0 : i_item.count - CNT_W'(1);
                    end else if (store) begin
                        r_left <= r_left - CNT_W'(1);
                    end
                end
                OP_COMMIT: r_cm_end <= r_st_end;
                OP_READ:   r_rd_pos <= PTR_W'(rd_adv);
                default:   ;
            endcase
        end
    end

    // ring memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.acc && store) begin
            mem[r_st_end] <= i_item.data_in;
        end
        if (i_cmd.rd_en) begin
            r_rd_q <= mem[r_burst_ptr];
        end
    end

    // burst walker and result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_burst_left <= '0;
        end else if (i_cmd.acc) begin
            r_burst_left <= BL_W'(n_bytes);
        end else if (i_cmd.rd_en) begin
            r_burst_left <= r_burst_left - BL_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.acc) begin
            r_burst_ptr <= r_rd_pos;
            r_res_fill  <= SIZE_W'(fill_after);
            r_res_free  <= SIZE_W'(size_x - fill_after);
        end else if (i_cmd.rd_en) begin
            r_burst_ptr <= PTR_W'(bp_inc);
        end
        if (i_cmd.meta_load) begin
            r_s1_byte   <= 1'b0;
            r_s1_last   <= 1'b1;
            r_s1_status <= meta_status;
        end else if (i_cmd.rd_en) begin
            r_s1_byte   <= 1'b1;
            r_s1_last   <= o_sts.last_issue;
            r_s1_status <= ST_OK;
        end
        if (i_cmd.out_load) begin
            r_out.data_out   <= r_s1_byte ? r_rd_q : 8'd0;
            r_out.byte_valid <= r_s1_byte;
            r_out.last       <= r_s1_last;
            r_out.status     <= r_s1_status;
            r_out.fill_level <= r_res_fill;
            r_out.free_space <= r_res_free;
        end
    end

    assign o_result = r_out;

endmodule

// File: hw/rtl/byte_ring_fifo_staged_commit.sv
// Top level of the byte ring FIFO with staged writes and commit.
// Depends on brf_pkg, brf_ctrl and brf_dp.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_item) carries one item: an
//   opcode (write byte, commit, read, peek, status) with its data byte,
//   block-first flag and count. Output channel (o_out_valid / i_out_ready /
//   o_result) returns results. Write, commit, status, empty read and empty
//   peek items give one result; a read or peek with n bytes available gives n
//   byte results, the final one marked last.
//   A single result passes through the result stage, then the output register;
//   a burst byte is read from the ring memory into the stage, then moved out.
//   Throughput: one single-result item per cycle while the receiver keeps up;
//   a burst holds the input until its last byte read is issued, paced by the
//   memory's single read port at one byte per cycle unless the output stalls.
//   A one-entry result stage in front of the output register lets the next
//   item be taken while a finished result still waits on the receiver.
//   Receiver stall: the output register holds; the stage fills and then the
//   input channel and burst reads pause until space frees up.
//   Reset (i_rst_n low, synchronous) empties the ring, clears the read, commit
//   and staged-end pointers and sets ring size to 1024 (or DEPTH if smaller).
//   No memory clearing pass. Writing i_cfg_data (i_cfg_we) sets the ring size,
//   clamped to 2..DEPTH, and flushes the FIFO. Only write it while idle.
module byte_ring_fifo_staged_commit #(
    parameter int DEPTH     = brf_pkg::DEPTH_DEF,
    parameter int MAX_BURST = brf_pkg::MAX_BURST_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  brf_pkg::t_in               i_item,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output brf_pkg::t_out              o_result,
    input  logic                       i_cfg_we,
    input  logic [brf_pkg::SIZE_W-1:0] i_cfg_data
);
    import brf_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // FSM: idle / burst, plus stage and output valid flags
    brf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // pointers, ring memory, result stage, output register
    brf_dp #(
        .DEPTH     (DEPTH),
        .MAX_BURST (MAX_BURST)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (i_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_result   (o_result)
    );

endmodule

// File: hw/rtl/brf_checker.sv
// Port-level checker for byte_ring_fifo_staged_commit, bound to the top level.
// Depends on brf_pkg.
module brf_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          o_out_valid,
    input logic          i_out_ready,
    input brf_pkg::t_out o_result
);
    import brf_pkg::*;

    // output valid drops after reset
    a_rst_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_result))
        else $error("stalled result changed");

    // non-byte results are single, last, with zero data
    a_meta: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_result.byte_valid |->
            o_result.last && o_result.data_out == 8'd0)
        else $error("bad non-byte result");

    // byte results always carry ok status
    a_byte_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_result.byte_valid |-> o_result.status == ST_OK)
        else $error("byte result with bad status");

    // status stays within defined codes
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_result.status == ST_OK || o_result.status == ST_OVERFLOW
                         || o_result.status == ST_EMPTY))
        else $error("undefined status code");

endmodule

bind byte_ring_fifo_staged_commit brf_checker u_brf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_result    (o_result)
);
